>>> hw/rtl/ksel_pkg.sv
// Shared types and constants of the k-th smallest selection block.
// Used by ksel_engine and kth_smallest_select; depends on nothing.
package ksel_pkg;

   localparam int VALUE_W    = 32;
   localparam int RANK_W     = 11;
   localparam int REQ_DATA_W = 48;

   typedef enum logic [1:0] {
      TOP_LOAD,
      TOP_SELECT,
      TOP_FINISH
   } top_state_type;

   typedef enum logic [4:0] {
      ENG_IDLE,
      ENG_CHECK,
      ENG_END_RD,
      ENG_END_CMP,
      ENG_END_WR,
      ENG_RD_K,
      ENG_RESULT,
      ENG_MED_X,
      ENG_MED_Y,
      ENG_MED_Z,
      ENG_MED_W,
      ENG_MED_CS2,
      ENG_MED_CS3,
      ENG_MED_WR1,
      ENG_MED_WR2,
      ENG_I_START,
      ENG_I_TEST,
      ENG_J_START,
      ENG_J_TEST,
      ENG_DECIDE,
      ENG_SWAP1,
      ENG_SWAP2,
      ENG_FIN1,
      ENG_FIN2
   } eng_state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_status_type;

endpackage

>>> hw/rtl/kth_smallest_select.sv
// Top level of the k-th smallest selection block: loading, result register, RAM.
// Instantiates ksel_ram and ksel_engine; uses types and constants from ksel_pkg.
//
// Usage. Elements of a set arrive on the req_ channel, one per transaction, and
// are written to the element RAM as they are accepted. The transaction with
// req_tlast high is stored too and carries the wanted rank k (from 1). The
// block then runs a partition selection in place over the stored set and
// returns one transaction on the rsp_ channel: the k-th smallest value, or
// error with value 0 when k lies outside 1..count or the set overflowed the
// store. Items arriving while the store is full are dropped.
// Throughput: loading takes 1 cycle per element. Selection is bound by the
// single read port of the RAM: each partition pass reads its range through that
// port one entry at a time, and the narrowed range shrinks by about half on
// average. A rejected rank or an overflowed set skips selection; its error
// answer goes via the finish state to the output register once that is free.
// req_tready is low during selection and until the answer has moved into the
// output register. A result waiting on a stalled receiver does not block
// loading of the next set; the next result waits.
// Reset clears the element count, the overflow flag and all handshakes; the
// RAM is not cleared, since only written entries are ever read.
module kth_smallest_select #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ksel_pkg::REQ_DATA_W-1:0]   req_tdata,  // value [31:0], rank [42:32]
   input  logic                              req_tlast,  // last element of the set
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ksel_pkg::VALUE_W-1:0]      rsp_tdata,  // selected [31:0]
   output logic                              rsp_tuser   // error [0]
);

   localparam int AW   = $clog2(MAX_ELEMENTS);
   localparam int PW   = $clog2(MAX_ELEMENTS + 2);
   localparam int CW   = $clog2(MAX_ELEMENTS + 1);
   localparam int CMPW = (CW > ksel_pkg::RANK_W) ? CW : ksel_pkg::RANK_W;

   ksel_pkg::top_state_type  state_ff, state_in;
   ksel_pkg::eng_status_type eng_status;

   logic [CW-1:0] count_ff, count_in, count_next;
   logic          overflow_ff, overflow_in, overflow_next;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ksel_pkg::VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_error_ff, rsp_error_in;
   logic [ksel_pkg::VALUE_W-1:0] pend_data_ff, pend_data_in;
   logic          pend_error_ff, pend_error_in;

   logic [ksel_pkg::VALUE_W-1:0] req_value;
   logic [ksel_pkg::RANK_W-1:0]  req_rank;
   logic          accept, room, set_error, slot_free, load_wr_en, eng_start;

   logic                         eng_wr_en, eng_rd_en;
   logic [AW-1:0]                eng_wr_addr, eng_rd_addr;
   logic [ksel_pkg::VALUE_W-1:0] eng_wr_data, eng_result, ram_rd_data;
   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [ksel_pkg::VALUE_W-1:0] ram_wr_data;

   assign req_value = req_tdata[ksel_pkg::VALUE_W-1:0];
   assign req_rank  = req_tdata[ksel_pkg::VALUE_W +: ksel_pkg::RANK_W];
   assign accept    = req_tvalid && req_tready;
   assign room      = (count_ff < CW'(MAX_ELEMENTS));

   // The last transaction counts itself before the rank is checked.
   assign count_next    = room ? (count_ff + CW'(1)) : count_ff;
   assign overflow_next = overflow_ff || !room;
   assign set_error     = overflow_next || (req_rank == '0)
                          || (CMPW'(req_rank) > CMPW'(count_next));
   assign slot_free     = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ksel_pkg::TOP_LOAD: begin
            if (accept && req_tlast) begin
               state_in = set_error ? ksel_pkg::TOP_FINISH : ksel_pkg::TOP_SELECT;
            end
         end
         ksel_pkg::TOP_SELECT: begin
            if (eng_status.done) begin
               state_in = ksel_pkg::TOP_FINISH;
            end
         end
         ksel_pkg::TOP_FINISH: begin
            if (slot_free) begin
               state_in = ksel_pkg::TOP_LOAD;
            end
         end
         default: state_in = ksel_pkg::TOP_LOAD;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready = (state_ff == ksel_pkg::TOP_LOAD);
      load_wr_en = (state_ff == ksel_pkg::TOP_LOAD) && accept && room;
      eng_start  = (state_ff == ksel_pkg::TOP_LOAD) && accept && req_tlast && !set_error;
   end

   // Set bookkeeping and the result register.
   always_comb begin
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      pend_data_in  = pend_data_ff;
      pend_error_in = pend_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_error_in  = rsp_error_ff;
      case (state_ff)
         ksel_pkg::TOP_LOAD: begin
            if (accept) begin
               if (req_tlast) begin
                  count_in      = '0;
                  overflow_in   = 1'b0;
                  pend_data_in  = '0;
                  pend_error_in = set_error;
               end else begin
                  count_in    = count_next;
                  overflow_in = overflow_next;
               end
            end
         end
         ksel_pkg::TOP_SELECT: begin
            if (eng_status.done) begin
               pend_data_in = eng_result;
            end
         end
         ksel_pkg::TOP_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_data_ff;
               rsp_error_in = pend_error_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ksel_pkg::TOP_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_error_ff  <= rsp_error_in;
      pend_data_ff  <= pend_data_in;
      pend_error_ff <= pend_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_error_ff;

   // The engine is idle while loading, so the write port belongs to the loader then.
   assign ram_wr_en   = load_wr_en || eng_wr_en;
   assign ram_wr_addr = load_wr_en ? count_ff[AW-1:0] : eng_wr_addr;
   assign ram_wr_data = load_wr_en ? req_value : eng_wr_data;

   ksel_ram #(
      .WIDTH (ksel_pkg::VALUE_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (eng_rd_en),
      .rd_addr (eng_rd_addr),
      .rd_data (ram_rd_data)
   );

   ksel_engine #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (eng_start),
      .n           (PW'(count_next)),
      .k           (PW'(req_rank)),
      .status      (eng_status),
      .result      (eng_result),
      .ram_wr_en   (eng_wr_en),
      .ram_wr_addr (eng_wr_addr),
      .ram_wr_data (eng_wr_data),
      .ram_rd_en   (eng_rd_en),
      .ram_rd_addr (eng_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_load_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> eng_status.idle)
      else $error("input accepted while the selection engine is busy");

   a_done_in_select: assert property (@(posedge clock) disable iff (reset)
      eng_status.done |-> (state_ff == ksel_pkg::TOP_SELECT))
      else $error("engine finished outside of a selection");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error result carries a nonzero value");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count exceeds the store depth");
`endif

endmodule

>>> hw/rtl/ksel_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module ksel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/ksel_engine.sv
// Partition selection sequencer: median-of-three pivot, inward scans, narrowing.
// Drives the ports of one ksel_ram; uses types from ksel_pkg.
module ksel_engine #(
   parameter int MAX_ELEMENTS = 1024,
   localparam int AW = $clog2(MAX_ELEMENTS),
   localparam int PW = $clog2(MAX_ELEMENTS + 2)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [PW-1:0]                  n,
   input  logic [PW-1:0]                  k,
   output ksel_pkg::eng_status_type       status,
   output logic [ksel_pkg::VALUE_W-1:0]   result,
   output logic                           ram_wr_en,
   output logic [AW-1:0]                  ram_wr_addr,
   output logic [ksel_pkg::VALUE_W-1:0]   ram_wr_data,
   output logic                           ram_rd_en,
   output logic [AW-1:0]                  ram_rd_addr,
   input  logic [ksel_pkg::VALUE_W-1:0]   ram_rd_data
);

   ksel_pkg::eng_state_type state_ff, state_in;

   // Positions are counted from 1, as entry p lives at address p-1.
   logic [PW-1:0] lo_ff, lo_in, hi_ff, hi_in, k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic signed [ksel_pkg::VALUE_W-1:0] va_ff, va_in, vb_ff, vb_in;
   logic signed [ksel_pkg::VALUE_W-1:0] vc_ff, vc_in, vd_ff, vd_in;
   logic signed [ksel_pkg::VALUE_W-1:0] vi_ff, vi_in, vj_ff, vj_in;

   logic signed [ksel_pkg::VALUE_W-1:0] rd_val;
   logic [PW-1:0] lo_p1, i_p1, j_m1, mid;
   logic [PW:0]   mid_sum;
   logic          narrow, pair, i_go, j_go;

   function automatic logic [AW-1:0] pos_addr(input logic [PW-1:0] pos);
      logic [PW-1:0] t;
      t = pos - PW'(1);
      return t[AW-1:0];
   endfunction

   assign rd_val  = signed'(ram_rd_data);
   assign lo_p1   = lo_ff + PW'(1);
   assign i_p1    = i_ff + PW'(1);
   assign j_m1    = j_ff - PW'(1);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[PW:1];
   assign narrow  = (hi_ff <= lo_p1);
   assign pair    = (hi_ff == lo_p1);
   assign i_go    = (i_p1 < hi_ff);
   assign j_go    = (j_m1 > lo_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ksel_pkg::ENG_IDLE: begin
            if (start) begin
               state_in = ksel_pkg::ENG_CHECK;
            end
         end
         ksel_pkg::ENG_CHECK: begin
            if (narrow) begin
               state_in = pair ? ksel_pkg::ENG_END_RD : ksel_pkg::ENG_RESULT;
            end else begin
               state_in = ksel_pkg::ENG_MED_X;
            end
         end
         ksel_pkg::ENG_END_RD:  state_in = ksel_pkg::ENG_END_CMP;
         ksel_pkg::ENG_END_CMP: begin
            state_in = (rd_val < va_ff) ? ksel_pkg::ENG_END_WR : ksel_pkg::ENG_RD_K;
         end
         ksel_pkg::ENG_END_WR:  state_in = ksel_pkg::ENG_RD_K;
         ksel_pkg::ENG_RD_K:    state_in = ksel_pkg::ENG_RESULT;
         ksel_pkg::ENG_RESULT:  state_in = ksel_pkg::ENG_IDLE;
         ksel_pkg::ENG_MED_X:   state_in = ksel_pkg::ENG_MED_Y;
         ksel_pkg::ENG_MED_Y:   state_in = ksel_pkg::ENG_MED_Z;
         ksel_pkg::ENG_MED_Z:   state_in = ksel_pkg::ENG_MED_W;
         ksel_pkg::ENG_MED_W:   state_in = ksel_pkg::ENG_MED_CS2;
         ksel_pkg::ENG_MED_CS2: state_in = ksel_pkg::ENG_MED_CS3;
         ksel_pkg::ENG_MED_CS3: state_in = ksel_pkg::ENG_MED_WR1;
         ksel_pkg::ENG_MED_WR1: state_in = ksel_pkg::ENG_MED_WR2;
         ksel_pkg::ENG_MED_WR2: state_in = ksel_pkg::ENG_I_START;
         ksel_pkg::ENG_I_START: begin
            state_in = i_go ? ksel_pkg::ENG_I_TEST : ksel_pkg::ENG_J_START;
         end
         ksel_pkg::ENG_I_TEST: begin
            if (rd_val < vd_ff && i_go) begin
               state_in = ksel_pkg::ENG_I_TEST;
            end else begin
               state_in = ksel_pkg::ENG_J_START;
            end
         end
         ksel_pkg::ENG_J_START: begin
            state_in = j_go ? ksel_pkg::ENG_J_TEST : ksel_pkg::ENG_DECIDE;
         end
         ksel_pkg::ENG_J_TEST: begin
            if (rd_val > vd_ff && j_go) begin
               state_in = ksel_pkg::ENG_J_TEST;
            end else begin
               state_in = ksel_pkg::ENG_DECIDE;
            end
         end
         ksel_pkg::ENG_DECIDE: begin
            state_in = (j_ff < i_ff) ? ksel_pkg::ENG_FIN1 : ksel_pkg::ENG_SWAP1;
         end
         ksel_pkg::ENG_SWAP1: state_in = ksel_pkg::ENG_SWAP2;
         ksel_pkg::ENG_SWAP2: state_in = ksel_pkg::ENG_I_START;
         ksel_pkg::ENG_FIN1:  state_in = ksel_pkg::ENG_FIN2;
         ksel_pkg::ENG_FIN2:  state_in = ksel_pkg::ENG_CHECK;
         default:             state_in = ksel_pkg::ENG_IDLE;
      endcase
   end

   // Memory port and status outputs.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_addr(lo_ff);
      ram_wr_data = va_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_addr(k_ff);
      status.idle = (state_ff == ksel_pkg::ENG_IDLE);
      status.done = (state_ff == ksel_pkg::ENG_RESULT);
      result      = ram_rd_data;
      case (state_ff)
         ksel_pkg::ENG_CHECK: begin
            ram_rd_en = 1'b1;
            if (narrow) begin
               ram_rd_addr = pair ? pos_addr(lo_ff) : pos_addr(k_ff);
            end else begin
               ram_rd_addr = pos_addr(mid);
            end
         end
         ksel_pkg::ENG_END_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_addr(hi_ff);
         end
         ksel_pkg::ENG_END_CMP: begin
            ram_wr_en   = (rd_val < va_ff);
            ram_wr_addr = pos_addr(lo_ff);
            ram_wr_data = ram_rd_data;
         end
         ksel_pkg::ENG_END_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(hi_ff);
            ram_wr_data = va_ff;
         end
         ksel_pkg::ENG_RD_K: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_addr(k_ff);
         end
         ksel_pkg::ENG_MED_X: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_addr(lo_p1);
         end
         ksel_pkg::ENG_MED_Y: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_addr(hi_ff);
         end
         ksel_pkg::ENG_MED_Z: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_addr(lo_ff);
         end
         ksel_pkg::ENG_MED_W: begin
            // The element that sat next to the low end moves to the middle.
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(mid);
            ram_wr_data = vb_ff;
         end
         ksel_pkg::ENG_MED_WR1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(lo_p1);
            ram_wr_data = va_ff;
         end
         ksel_pkg::ENG_MED_WR2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(hi_ff);
            ram_wr_data = vc_ff;
         end
         ksel_pkg::ENG_I_START: begin
            ram_rd_en   = i_go;
            ram_rd_addr = pos_addr(i_p1);
         end
         ksel_pkg::ENG_I_TEST: begin
            ram_rd_en   = i_go;
            ram_rd_addr = pos_addr(i_p1);
         end
         ksel_pkg::ENG_J_START: begin
            ram_rd_en   = j_go;
            ram_rd_addr = pos_addr(j_m1);
         end
         ksel_pkg::ENG_J_TEST: begin
            ram_rd_en   = j_go;
            ram_rd_addr = pos_addr(j_m1);
         end
         ksel_pkg::ENG_SWAP1: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(i_ff);
            ram_wr_data = vj_ff;
         end
         ksel_pkg::ENG_SWAP2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(j_ff);
            ram_wr_data = vi_ff;
         end
         ksel_pkg::ENG_FIN1: begin
            // When the downward scan reached the low end, the pivot stays there.
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(lo_ff);
            ram_wr_data = (j_ff == lo_ff) ? vd_ff : vj_ff;
         end
         ksel_pkg::ENG_FIN2: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_addr(j_ff);
            ram_wr_data = vd_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      k_in  = k_ff;
      i_in  = i_ff;
      j_in  = j_ff;
      va_in = va_ff;
      vb_in = vb_ff;
      vc_in = vc_ff;
      vd_in = vd_ff;
      vi_in = vi_ff;
      vj_in = vj_ff;
      case (state_ff)
         ksel_pkg::ENG_IDLE: begin
            if (start) begin
               lo_in = PW'(1);
               hi_in = n;
               k_in  = k;
            end
         end
         ksel_pkg::ENG_END_RD: va_in = rd_val;
         ksel_pkg::ENG_MED_X:  va_in = rd_val;
         ksel_pkg::ENG_MED_Y:  vb_in = rd_val;
         ksel_pkg::ENG_MED_Z:  vc_in = rd_val;
         ksel_pkg::ENG_MED_W: begin
            vd_in = rd_val;
            if (va_ff > vc_ff) begin
               va_in = vc_ff;
               vc_in = va_ff;
            end
         end
         ksel_pkg::ENG_MED_CS2: begin
            if (vd_ff > vc_ff) begin
               vd_in = vc_ff;
               vc_in = vd_ff;
            end
         end
         ksel_pkg::ENG_MED_CS3: begin
            if (va_ff > vd_ff) begin
               va_in = vd_ff;
               vd_in = va_ff;
            end
         end
         ksel_pkg::ENG_MED_WR2: begin
            i_in = lo_p1;
            j_in = hi_ff;
         end
         ksel_pkg::ENG_I_START: i_in = i_p1;
         ksel_pkg::ENG_I_TEST: begin
            if (rd_val < vd_ff) begin
               i_in = i_p1;
            end else begin
               vi_in = rd_val;
            end
         end
         ksel_pkg::ENG_J_START: j_in = j_m1;
         ksel_pkg::ENG_J_TEST: begin
            if (rd_val > vd_ff) begin
               j_in = j_m1;
            end else begin
               vj_in = rd_val;
            end
         end
         ksel_pkg::ENG_FIN2: begin
            if (j_ff >= k_ff) begin
               hi_in = j_m1;
            end
            if (j_ff <= k_ff) begin
               lo_in = i_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksel_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      k_ff  <= k_in;
      i_ff  <= i_in;
      j_ff  <= j_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
      vc_ff <= vc_in;
      vd_ff <= vd_in;
      vi_ff <= vi_in;
      vj_ff <= vj_in;
   end

`ifndef SYNTHESIS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("engine reads and writes the same entry in one cycle");

   a_up_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksel_pkg::ENG_I_TEST) |-> (i_ff < hi_ff))
      else $error("upward scan ran past the high end");

   a_down_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksel_pkg::ENG_J_TEST) |-> (j_ff > lo_ff))
      else $error("downward scan ran past the low end");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ksel_pkg::ENG_IDLE))
      else $error("selection started while busy");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench of kth_smallest_select: directed table, then random sets.
// Depends on ksel_pkg and kth_smallest_select; the expected answers come from an
// in-bench partition selection that tracks the stored set.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W    = ksel_pkg::VALUE_W;
   localparam int RANK_W     = ksel_pkg::RANK_W;
   localparam int REQ_DATA_W = ksel_pkg::REQ_DATA_W;

   // The store is built smaller than its default so that full and overflowed sets
   // take only a few hundred transactions each.
   localparam int ELEM_CAPACITY = 256;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_MAX    = 10;

   localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic [RANK_W-1:0]         rank;
      bit                        typed;     // answer below is written into the table
      logic signed [VALUE_W-1:0] sel;
      logic                      err;
   } element_row_type;

   typedef struct {
      logic signed [VALUE_W-1:0] sel;
      logic                      err;
   } answer_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_W-1:0]       req_tdata = '0;
   logic                        req_tlast = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [VALUE_W-1:0]          rsp_tdata;
   logic                        rsp_tuser;

   // Shadow of the element store and of the load state.
   logic signed [VALUE_W-1:0]   shadow_set [ELEM_CAPACITY];
   int unsigned                 shadow_count = 0;
   bit                          shadow_overflow = 1'b0;

   answer_type                  pending_answers [$];
   element_row_type             directed_rows [$];

   int                          fail_count = 0;
   int                          answers_checked = 0;
   int                          items_sent = 0;
   int                          sets_sent = 0;
   int                          error_sets = 0;
   int                          overflow_sets = 0;
   int                          cycle_count = 0;
   int                          burst_left = 0;

   kth_smallest_select #(
      .MAX_ELEMENTS(ELEM_CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value [31:0], rank [42:32]
      .req_tlast  (req_tlast),   // last element of the set
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // selected [31:0]
      .rsp_tuser  (rsp_tuser)    // error [0]
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Cycle counter that ends a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d answers still outstanding.",
                  cycle_count, pending_answers.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void shadow_swap(int unsigned a, int unsigned b);
      logic signed [VALUE_W-1:0] t;
      t = shadow_set[a];
      shadow_set[a] = shadow_set[b];
      shadow_set[b] = t;
   endfunction

   // Partition selection over shadow_set[0..n-1], done in place exactly as the block
   // does it, since later sets never see the rearranged order but the pivot choice
   // depends on it within one set. Positions lo, hi, k are counted from 1.
   function automatic logic signed [VALUE_W-1:0] rank_select(int unsigned n, int unsigned k);
      int unsigned lo, hi, mid, i, j;
      logic signed [VALUE_W-1:0] pivot;
      lo = 1;
      hi = n;
      while (1'b1) begin
         if (hi <= lo + 1) begin
            if (hi == lo + 1 && shadow_set[hi-1] < shadow_set[lo-1])
               shadow_swap(lo - 1, hi - 1);
            return shadow_set[k-1];
         end
         // Median of three goes to position lo, the smallest to lo+1, the largest to hi.
         mid = (lo + hi) >> 1;
         shadow_swap(mid - 1, lo);
         if (shadow_set[lo] > shadow_set[hi-1])
            shadow_swap(lo, hi - 1);
         if (shadow_set[lo-1] > shadow_set[hi-1])
            shadow_swap(lo - 1, hi - 1);
         if (shadow_set[lo] > shadow_set[lo-1])
            shadow_swap(lo, lo - 1);
         i = lo + 1;
         j = hi;
         pivot = shadow_set[lo-1];
         while (1'b1) begin
            do i++; while (i < hi && shadow_set[i-1] < pivot);
            do j--; while (j > lo && shadow_set[j-1] > pivot);
            if (j < i)
               break;
            shadow_swap(i - 1, j - 1);
         end
         shadow_set[lo-1] = shadow_set[j-1];
         shadow_set[j-1] = pivot;
         // Narrow to the side that holds rank k; both bounds move when j hits k.
         if (j >= k)
            hi = j - 1;
         if (j <= k)
            lo = i;
      end
      return '0;
   endfunction

   // Takes one accepted element into the shadow state; returns 1 when the element
   // closes a set, with the answer the block owes for it.
   function automatic bit absorb_element(input element_row_type row, output answer_type ans);
      ans.sel = '0;
      ans.err = 1'b0;
      if (shadow_count < ELEM_CAPACITY) begin
         shadow_set[shadow_count] = row.value;
         shadow_count++;
      end else begin
         shadow_overflow = 1'b1;
      end
      if (!row.last)
         return 1'b0;
      ans.err = shadow_overflow || row.rank == 0 || row.rank > shadow_count;
      if (!ans.err)
         ans.sel = rank_select(shadow_count, row.rank);
      shadow_count = 0;
      shadow_overflow = 1'b0;
      return 1'b1;
   endfunction

   // Drives one element and waits for its transaction. The sender runs in bursts;
   // between bursts req_tvalid drops for a random gap, and some bursts come with
   // no gap at all so that back-to-back loading is covered too.
   task automatic send_element(input element_row_type row);
      int         gap;
      answer_type ans;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 7))
            0, 1, 2: gap = 0;
            7:       gap = $urandom_range(10, 40);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - RANK_W - VALUE_W){1'b0}}, row.rank, row.value};
      req_tlast  <= row.last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (absorb_element(row, ans)) begin
         sets_sent++;
         if (ans.err)
            error_sets++;
         if (row.typed) begin
            ans.sel = row.sel;
            ans.err = row.err;
         end
         pending_answers.push_back(ans);
      end
   endtask

   // Table row builder; a typed row carries its answer, the rest rely on the shadow.
   task automatic add_row(input logic signed [VALUE_W-1:0] value, input logic last,
                          input int rank, input bit typed,
                          input logic signed [VALUE_W-1:0] sel, input logic err);
      element_row_type row;
      row.value = value;
      row.last  = last;
      row.rank  = rank[RANK_W-1:0];
      row.typed = typed;
      row.sel   = sel;
      row.err   = err;
      directed_rows.push_back(row);
   endtask

   // The receiver switches among stall patterns of its own: always ready, mostly
   // ready, alternating, and long stalls.
   int sink_mode = 0;
   int sink_left = 0;
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode = $urandom_range(0, 3);
         sink_left = $urandom_range(20, 300);
      end else begin
         sink_left--;
      end
      case (sink_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ~rsp_tready;
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Every answer transaction is checked against the oldest outstanding answer.
   always @(posedge clock) begin
      answer_type exp_ans;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("Unexpected answer at cycle %0d: selected %0d error %0b",
                        cycle_count, $signed(rsp_tdata), rsp_tuser);
         end else begin
            exp_ans = pending_answers.pop_front();
            answers_checked++;
            if (rsp_tdata !== exp_ans.sel || rsp_tuser !== exp_ans.err) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("Mismatch on answer %0d: selected %0d/%0d error %0b/%0b (exp/act)",
                           answers_checked, exp_ans.sel, $signed(rsp_tdata),
                           exp_ans.err, rsp_tuser);
            end
         end
      end
   end

   initial begin
      element_row_type row;
      int           n, rank, mode, step, random_items, set_index, i;
      logic signed [VALUE_W-1:0] base;

      // Singleton sets: the only element, then a rank of zero.
      add_row(32'sd5, 1'b1, 1, 1'b1, 32'sd5, 1'b0);
      add_row(32'sd9, 1'b1, 0, 1'b1, '0, 1'b1);
      // Two elements, the upper rank.
      add_row(-32'sd1, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd3, 1'b1, 2, 1'b0, '0, 1'b0);
      // Extremes of the key, picked from either end.
      add_row(KEY_MAX, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(KEY_MIN, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd0, 1'b1, 1, 1'b1, KEY_MIN, 1'b0);
      add_row(KEY_MIN, 1'b0, 2047, 1'b0, '0, 1'b0);
      add_row(32'sd0, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(KEY_MAX, 1'b1, 3, 1'b1, KEY_MAX, 1'b0);
      // Rank one above the count, then the all-ones rank.
      add_row(32'sd1, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd2, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd3, 1'b1, 4, 1'b1, '0, 1'b1);
      add_row(32'sd4, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd4, 1'b1, 2047, 1'b1, '0, 1'b1);
      // Descending run, middle rank.
      add_row(32'sd50, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd40, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd30, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd20, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd10, 1'b1, 3, 1'b0, '0, 1'b0);
      // Equal keys: a rank far above the count on a short set, then a middle rank.
      add_row(32'sd7, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(32'sd7, 1'b1, 1024, 1'b1, '0, 1'b1);
      add_row(-32'sd3, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(-32'sd3, 1'b0, 0, 1'b0, '0, 1'b0);
      add_row(-32'sd3, 1'b1, 2, 1'b0, '0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_element(directed_rows[r]);

      // Random sets. Most are short; a few reach the store size, and two overflow
      // it, once with the last element itself dropped and once with extra elements.
      random_items = 0;
      set_index = 0;
      while (random_items < RANDOM_ITEMS) begin
         set_index++;
         if (set_index == 3)
            n = ELEM_CAPACITY;
         else if (set_index == 12)
            n = ELEM_CAPACITY + 1;
         else if (set_index == 24)
            n = ELEM_CAPACITY + 3;
         else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(25, 64);
         else
            n = $urandom_range(1, 24);
         if (n > ELEM_CAPACITY)
            overflow_sets++;
         case ($urandom_range(0, 19))
            0:       rank = 0;
            1:       rank = $urandom_range(n + 1, 2047);
            2:       rank = n;
            3:       rank = 1;
            default: rank = $urandom_range(1, (n > ELEM_CAPACITY) ? ELEM_CAPACITY : n);
         endcase
         mode = $urandom_range(0, 5);
         base = $urandom;
         step = $urandom_range(1, 1000);
         for (i = 0; i < n; i++) begin
            case (mode)
               0: row.value = $urandom;
               1: row.value = int'($urandom_range(0, 15)) - 8;    // many duplicates
               2: row.value = base + i * step;                     // ascending
               3: row.value = base - i * step;                     // descending
               4: row.value = base;                                // all equal
               default: begin
                  case ($urandom_range(0, 4))
                     0: row.value = KEY_MIN;
                     1: row.value = KEY_MAX;
                     2: row.value = 32'sd0;
                     3: row.value = -32'sd1;
                     default: row.value = 32'sd1;
                  endcase
               end
            endcase
            row.last  = (i == n - 1);
            // The rank field is ignored away from the last element; it still toggles.
            row.rank  = row.last ? rank[RANK_W-1:0] : RANK_W'($urandom);
            row.typed = 1'b0;
            row.sel   = '0;
            row.err   = 1'b0;
            send_element(row);
            random_items++;
         end
      end
      req_tvalid <= 1'b0;

      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Loaded %0d elements in %0d sets (%0d overflowing the store of %0d).",
               items_sent, sets_sent, overflow_sets, ELEM_CAPACITY);
      $display("Checked %0d answers, %0d of them errors; %0d failures.",
               answers_checked, error_sets, fail_count);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
